### hdl/bfwc_pkg.sv
// shared widths, constants, register indexes and sequencer states of the window controller
`default_nettype none

package bfwc_pkg;

  // field widths
  localparam int BYTES_W    = 31;
  localparam int ELAPSED_W  = 40;
  localparam int RTT_W      = 31;
  localparam int WIN_W      = 32;

  // register widths
  localparam int GAMMA_W    = 8;
  localparam int ALPHA_W    = 12;
  localparam int DELTA_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // arithmetic widths
  localparam int MICRO_W    = 20;
  localparam int EPS_NUM_W  = ALPHA_W + MICRO_W;
  localparam int RATE_NUM_W = BYTES_W + MICRO_W;
  localparam int WEIGHT_W   = 9;
  localparam int MAG_W      = 8;
  localparam int PCT_W      = 7;

  localparam logic [MICRO_W-1:0] MICRO   = 20'd1000000;
  localparam logic [PCT_W-1:0]   PERCENT = 7'd100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA = 2'd2;

  // register reset values
  localparam logic [GAMMA_W-1:0] GAMMA_RST = 8'd100;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 12'd100;
  localparam logic [DELTA_W-1:0] DELTA_RST = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_DIFF,
    ST_SCALE_GO,
    ST_SCALE,
    ST_WIN,
    ST_FIN
  } bfwc_state_t;

endpackage

`default_nettype wire

### hdl/bfwc_serdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module bfwc_serdiv #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    // dividend bits shift out at the top, quotient bits shift in at the bottom
    trial    = {rem_r, num_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quot = num_r;
  assign done = done_r;

endmodule

`default_nettype wire

### hdl/bfwc_pct.sv
// signed percent scaler: x * m / 100 toward zero, saturated, with a serial divide by 100
`default_nettype none

module bfwc_pct import bfwc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] x,
  input  logic signed [WEIGHT_W-1:0]    m,
  output logic signed [VALUE_WIDTH-1:0] y,
  output logic                          done
);

  localparam int PROD_W = VALUE_WIDTH + MAG_W;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [VALUE_WIDTH-1:0] ax_r, ax_nxt;
  logic [MAG_W-1:0]       am_r, am_nxt;
  logic                   neg_r, neg_nxt;
  logic                   armed_r;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      q;
  logic                   div_done;
  logic                   over;

  // sign and magnitude split; the magnitude of the most negative x fits unsigned
  assign ax_nxt  = x[VALUE_WIDTH-1] ? VALUE_WIDTH'(-x) : VALUE_WIDTH'(x);
  assign am_nxt  = m[WEIGHT_W-1] ? MAG_W'(-m) : m[MAG_W-1:0];
  assign neg_nxt = x[VALUE_WIDTH-1] ^ m[WEIGHT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else begin
      armed_r <= start;
    end
    if (start) begin
      ax_r  <= ax_nxt;
      am_r  <= am_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign prod = PROD_W'(ax_r) * PROD_W'(am_r);

  bfwc_serdiv #(
    .NUM_W (PROD_W),
    .DEN_W (PCT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (armed_r),
    .num   (prod),
    .den   (PERCENT),
    .quot  (q),
    .done  (div_done)
  );

  assign over = |q[PROD_W-1:VALUE_WIDTH-1];

  always_comb begin
    if (over) begin
      y = neg_r ? VMIN : VMAX;
    end else if (neg_r) begin
      y = -signed'(q[VALUE_WIDTH-1:0]);
    end else begin
      y = signed'(q[VALUE_WIDTH-1:0]);
    end
  end

  // the divider still shows the previous run while armed
  assign done = div_done & ~armed_r;

endmodule

`default_nettype wire

### hdl/background_flow_window_controller.sv
// top level of the background-flow window controller: sequencer, state and channel registers
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  bytes_sent, elapsed_us, rtt_us
//   out_     output     out_valid/out_stall  window_size, div_error
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word at a time: the time an item takes is set by
//   the 51-step serial rate divider and the VALUE_WIDTH + 8 step serial divide by 100
// a word with a zero elapsed time or rtt skips the dividers and goes straight to the finish state
// the output register holds a finished word, so the next word is taken while it waits
// reset (rst_n low, synchronous) restores the registers, window 1 and a zero rate history
// cfg_ready is always high; writes are to be made only while no word is in flight (the block does not enforce it)
`default_nettype none

module background_flow_window_controller import bfwc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTES_W-1:0]     in_bytes_sent,
  input  logic [ELAPSED_W-1:0]   in_elapsed_us,
  input  logic [RTT_W-1:0]       in_rtt_us,
  // result words
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [WIN_W-1:0] out_window_size,
  output logic                   out_div_error,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int VW = VALUE_WIDTH;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [64:0] VMAX_WIDE = (65'(1) << (VW - 1)) - 65'(1);

  // saturating add and subtract on the value width
  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_add = s[VW] ? VMIN : VMAX;
    end else begin
      sat_add = s[VW-1:0];
    end
  endfunction

  function automatic logic signed [VW-1:0] sat_sub(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_sub = s[VW] ? VMIN : VMAX;
    end else begin
      sat_sub = s[VW-1:0];
    end
  endfunction

  bfwc_state_t state_r, state_nxt;

  // registers written by the configuration port
  logic [GAMMA_W-1:0] gamma_r, gamma_nxt;
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;

  // controller state
  logic signed [VW-1:0] last_win_r, last_win_nxt;
  logic signed [VW-1:0] older_r, older_nxt;
  logic signed [VW-1:0] newer_r, newer_nxt;

  // working values of the word in flight
  logic                 err_r, err_nxt;
  logic signed [VW-1:0] eps_r, eps_nxt;
  logic signed [VW-1:0] rate_r, rate_nxt;
  logic signed [VW-1:0] sum_r, sum_nxt;
  logic signed [VW-1:0] raw_r, raw_nxt;
  logic signed [VW-1:0] adj_r, adj_nxt;
  logic signed [VW-1:0] ewa_r, ewa_nxt;
  logic signed [VW-1:0] ewb_r, ewb_nxt;
  logic signed [VW-1:0] win_r, win_nxt;
  logic signed [VW-1:0] ewma_r, ewma_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [WIN_W-1:0] out_window_r, out_window_nxt;
  logic                    out_err_r, out_err_nxt;

  logic in_fire;
  logic out_fire;
  logic out_load;
  logic div_start;
  logic pct_start;

  // dividers: epsilon and period rate
  logic [EPS_NUM_W-1:0]  eps_num, eps_q;
  logic [RATE_NUM_W-1:0] rate_num, rate_q;
  logic                  eps_done, rate_done;
  logic                  eps_over, rate_over;
  logic signed [VW-1:0]  eps_sat, rate_sat;

  // percent scalers: window gain, older ewma term, newer ewma term
  logic signed [WEIGHT_W-1:0] w_gain, w_old, w_new;
  logic signed [VW-1:0]       gain_y, ewa_y, ewb_y;
  logic                       gain_done, ewa_done, ewb_done;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid & ~in_stall;
  assign out_fire  = out_valid_r & ~out_stall;
  assign out_load  = ~out_valid_r | ~out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_window_size = out_window_r;
  assign out_div_error   = out_err_r;

  // scaled numerators go straight into the divider shift registers
  assign eps_num  = EPS_NUM_W'(alpha_r) * EPS_NUM_W'(MICRO);
  assign rate_num = RATE_NUM_W'(in_bytes_sent) * RATE_NUM_W'(MICRO);

  bfwc_serdiv #(
    .NUM_W (EPS_NUM_W),
    .DEN_W (RTT_W)
  ) u_eps_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (eps_num),
    .den   (in_rtt_us),
    .quot  (eps_q),
    .done  (eps_done)
  );

  bfwc_serdiv #(
    .NUM_W (RATE_NUM_W),
    .DEN_W (ELAPSED_W)
  ) u_rate_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rate_num),
    .den   (in_elapsed_us),
    .quot  (rate_q),
    .done  (rate_done)
  );

  // quotients are non-negative, clamp to the positive limit
  assign eps_over  = 65'(eps_q) > VMAX_WIDE;
  assign rate_over = 65'(rate_q) > VMAX_WIDE;
  assign eps_sat   = eps_over ? VMAX : VW'(eps_q);
  assign rate_sat  = rate_over ? VMAX : VW'(rate_q);

  // weights; a delta above one hundred makes the older weight negative
  assign w_gain = WEIGHT_W'(gamma_r);
  assign w_old  = WEIGHT_W'(PERCENT) - WEIGHT_W'(delta_r);
  assign w_new  = WEIGHT_W'(delta_r);

  bfwc_pct #(
    .VALUE_WIDTH (VW)
  ) u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pct_start),
    .x     (raw_r),
    .m     (w_gain),
    .y     (gain_y),
    .done  (gain_done)
  );

  bfwc_pct #(
    .VALUE_WIDTH (VW)
  ) u_ew_old (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pct_start),
    .x     (newer_r),
    .m     (w_old),
    .y     (ewa_y),
    .done  (ewa_done)
  );

  bfwc_pct #(
    .VALUE_WIDTH (VW)
  ) u_ew_new (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pct_start),
    .x     (rate_r),
    .m     (w_new),
    .y     (ewb_y),
    .done  (ewb_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gamma_r     <= GAMMA_RST;
      alpha_r     <= ALPHA_RST;
      delta_r     <= DELTA_RST;
      last_win_r  <= VW'(1);
      older_r     <= '0;
      newer_r     <= '0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gamma_r     <= gamma_nxt;
      alpha_r     <= alpha_nxt;
      delta_r     <= delta_nxt;
      last_win_r  <= last_win_nxt;
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      err_r       <= err_nxt;
    end
    eps_r        <= eps_nxt;
    rate_r       <= rate_nxt;
    sum_r        <= sum_nxt;
    raw_r        <= raw_nxt;
    adj_r        <= adj_nxt;
    ewa_r        <= ewa_nxt;
    ewb_r        <= ewb_nxt;
    win_r        <= win_nxt;
    ewma_r       <= ewma_nxt;
    out_window_r <= out_window_nxt;
    out_err_r    <= out_err_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    gamma_nxt      = gamma_r;
    alpha_nxt      = alpha_r;
    delta_nxt      = delta_r;
    last_win_nxt   = last_win_r;
    older_nxt      = older_r;
    newer_nxt      = newer_r;
    err_nxt        = err_r;
    eps_nxt        = eps_r;
    rate_nxt       = rate_r;
    sum_nxt        = sum_r;
    raw_nxt        = raw_r;
    adj_nxt        = adj_r;
    ewa_nxt        = ewa_r;
    ewb_nxt        = ewb_r;
    win_nxt        = win_r;
    ewma_nxt       = ewma_r;
    out_valid_nxt  = out_valid_r;
    out_window_nxt = out_window_r;
    out_err_nxt    = out_err_r;
    div_start      = 1'b0;
    pct_start      = 1'b0;

    // register writes; unknown indexes are dropped
    if (cfg_valid) begin
      case (cfg_index)
        CFG_GAMMA: gamma_nxt = cfg_data[GAMMA_W-1:0];
        CFG_ALPHA: alpha_nxt = cfg_data[ALPHA_W-1:0];
        CFG_DELTA: delta_nxt = cfg_data[DELTA_W-1:0];
        default: ;
      endcase
    end

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // a zero divisor skips the arithmetic and reports the held window
          err_nxt = (in_elapsed_us == '0) || (in_rtt_us == '0);
          if (err_nxt) begin
            state_nxt = ST_FIN;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (eps_done && rate_done) begin
          eps_nxt   = eps_sat;
          rate_nxt  = rate_sat;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt   = sat_add(eps_r, rate_r);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        raw_nxt   = sat_sub(sum_r, older_r);
        state_nxt = ST_SCALE_GO;
      end
      ST_SCALE_GO: begin
        pct_start = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (gain_done && ewa_done && ewb_done) begin
          adj_nxt   = gain_y;
          ewa_nxt   = ewa_y;
          ewb_nxt   = ewb_y;
          state_nxt = ST_WIN;
        end
      end
      ST_WIN: begin
        win_nxt   = sat_add(last_win_r, adj_r);
        ewma_nxt  = sat_add(ewa_r, ewb_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // wait for the output register, then publish and commit together
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_err_nxt    = err_r;
          out_window_nxt = err_r ? WIN_W'(last_win_r) : WIN_W'(win_r);
          if (!err_r) begin
            last_win_nxt = win_r;
            older_nxt    = newer_r;
            newer_nxt    = ewma_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // a taken word always leaves the idle state
  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("word taken but sequencer stayed idle");

  // the three percent scalers run in lockstep
  a_pct_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE) |-> ((gain_done == ewa_done) && (gain_done == ewb_done)))
    else $error("percent scalers out of step");

  // an error word carries the window that is still held
  a_err_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_window_r == WIN_W'(last_win_r)))
    else $error("error word does not match held window");

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking bench for the background-flow window controller
`timescale 1ns / 100ps

module testbench;
  import bfwc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 255;
  localparam int PRESSURE_AT    = 150;
  localparam int PRESSURE_HOLD  = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int PRINT_LIMIT    = 40;

  // the fourth register slot decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam bit [BYTES_W-1:0]   BYTES_MAX   = '1;
  localparam bit [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam bit [RTT_W-1:0]     RTT_MAX     = '1;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // one control period, optionally preceded by a register write
  typedef struct {
    bit                   cfg_en;
    logic [CFG_IDX_W-1:0] cfg_idx;
    bit [CFG_DATA_W-1:0]  cfg_val;
    bit [BYTES_W-1:0]     bytes;
    bit [ELAPSED_W-1:0]   elapsed;
    bit [RTT_W-1:0]       rtt;
    bit                   typed;
    bit [WIN_W-1:0]       typed_win;
    bit                   typed_err;
  } period_t;

  typedef struct {
    logic [WIN_W-1:0] window;
    logic             div_error;
  } window_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTES_W-1:0]    in_bytes_sent = '0;
  logic [ELAPSED_W-1:0]  in_elapsed_us = '0;
  logic [RTT_W-1:0]      in_rtt_us = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WIN_W-1:0]      out_window_size;
  logic                  out_div_error;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // controller image: registers and window / rate history
  bit [GAMMA_W-1:0] gain_pct   = GAMMA_RST;
  bit [ALPHA_W-1:0] alpha_num  = ALPHA_RST;
  bit [DELTA_W-1:0] weight_pct = DELTA_RST;
  longint win_now       = 1;
  longint rate_hist_old = 0;
  longint rate_hist_new = 0;

  window_word_t expected_words[$];
  period_t      directed_rows[$];
  window_word_t head_word;

  int  mismatches  = 0;
  int  words_sent  = 0;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;

  background_flow_window_controller u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_bytes_sent   (in_bytes_sent),
    .in_elapsed_us   (in_elapsed_us),
    .in_rtt_us       (in_rtt_us),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_size (out_window_size),
    .out_div_error   (out_div_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // clamp to a signed 32-bit value
  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // x * m / 100 with truncation toward zero, then clamped
  function automatic longint pct_of(longint x, longint m);
    longint mag;
    mag = ((x < 0) ? -x : x) * ((m < 0) ? -m : m) / 100;
    return sat_word(((x < 0) != (m < 0)) ? -mag : mag);
  endfunction

  // one control period: new window, then the rate history shifts
  function automatic window_word_t advance_window(period_t p);
    longint eps;
    longint rate;
    longint raw;
    longint win;
    longint ewma;
    window_word_t w;
    w.window    = win_now[WIN_W-1:0];
    w.div_error = 1'b1;
    // zero divisor: flag it, report the held window, touch nothing
    if (p.elapsed == '0 || p.rtt == '0) return w;
    eps  = sat_word(longint'(alpha_num) * 1000000 / longint'(p.rtt));
    rate = sat_word(longint'(p.bytes) * 1000000 / longint'(p.elapsed));
    raw  = sat_word(sat_word(eps + rate) + sat_word(-rate_hist_old));
    win  = sat_word(win_now + pct_of(raw, longint'(gain_pct)));
    // weight above one hundred makes the older weight negative
    ewma = sat_word(pct_of(rate_hist_new, 100 - longint'(weight_pct))
                    + pct_of(rate, longint'(weight_pct)));
    rate_hist_old = rate_hist_new;
    rate_hist_new = ewma;
    win_now       = win;
    w.window    = win[WIN_W-1:0];
    w.div_error = 1'b0;
    return w;
  endfunction

  // random value of the given width, biased toward varied magnitudes
  function automatic bit [63:0] wide_random(int unsigned width);
    bit [63:0] raw;
    int unsigned keep;
    raw = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       keep = width;
      1:       keep = $urandom_range(8, 1);
      default: keep = $urandom_range(width, 1);
    endcase
    if ($urandom_range(9) == 0) raw = '1;
    return raw & ((64'd1 << keep) - 64'd1);
  endfunction

  function automatic period_t random_period();
    period_t p;
    p.cfg_en    = 1'b0;
    p.cfg_idx   = CFG_GAMMA;
    p.cfg_val   = '0;
    p.typed     = 1'b0;
    p.typed_win = '0;
    p.typed_err = 1'b0;
    p.bytes     = BYTES_W'(wide_random(BYTES_W));
    p.elapsed   = ELAPSED_W'(wide_random(ELAPSED_W));
    p.rtt       = RTT_W'(wide_random(RTT_W));
    // a few zero divisors among mostly well-formed periods
    case ($urandom_range(29))
      0: p.elapsed = '0;
      1: p.rtt = '0;
      2: begin
        p.elapsed = '0;
        p.rtt = '0;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_row(bit cfg_en, logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val,
                         bit [BYTES_W-1:0] b, bit [ELAPSED_W-1:0] e, bit [RTT_W-1:0] r,
                         bit typed, bit [WIN_W-1:0] twin, bit terr);
    period_t p;
    p.cfg_en    = cfg_en;
    p.cfg_idx   = idx;
    p.cfg_val   = val;
    p.bytes     = b;
    p.elapsed   = e;
    p.rtt       = r;
    p.typed     = typed;
    p.typed_win = twin;
    p.typed_err = terr;
    directed_rows.push_back(p);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // register write, only once every result is back; valid drops with the next word
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GAMMA: gain_pct   = val[GAMMA_W-1:0];
      CFG_ALPHA: alpha_num  = val[ALPHA_W-1:0];
      CFG_DELTA: weight_pct = val[DELTA_W-1:0];
      default: ;
    endcase
  endtask

  // offer one period word; valid stays up when the next word follows directly
  task automatic send_period(period_t p);
    window_word_t w;
    cfg_valid <= 1'b0;
    if (!calm && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_bytes_sent <= p.bytes;
    in_elapsed_us <= p.elapsed;
    in_rtt_us     <= p.rtt;
    do @(posedge clk); while (in_stall);
    w = advance_window(p);
    if (p.typed) begin
      w.window    = p.typed_win;
      w.div_error = p.typed_err;
    end
    expected_words.push_back(w);
    words_sent++;
  endtask

  // main sequence: reset, directed table, random phases, drain
  initial begin : stimulus
    bit [CFG_DATA_W-1:0] g;
    bit [CFG_DATA_W-1:0] a;
    bit [CFG_DATA_W-1:0] d;

    // straight after reset an error word carries the reset window of one
    add_row(0, CFG_GAMMA, 0, 0, 0, 1, 1, 1, 1);
    add_row(0, CFG_GAMMA, 0, BYTES_MAX, 5, 0, 1, 1, 1);
    // epsilon of 100 at reset gains, no rate yet
    add_row(0, CFG_GAMMA, 0, 0, 1000000, 1000000, 1, 101, 0);
    // rate saturates, so does the window
    add_row(0, CFG_GAMMA, 0, BYTES_MAX, 1, 1, 1, 32'h7FFF_FFFF, 0);
    add_row(0, CFG_GAMMA, 0, BYTES_MAX, ELAPSED_MAX, RTT_MAX, 0, 0, 0);
    add_row(0, CFG_GAMMA, 0, 0, ELAPSED_MAX, RTT_MAX, 0, 0, 0);
    add_row(1, CFG_GAMMA, 12'd255, 0, 1, RTT_MAX, 0, 0, 0);
    // alpha beyond its nominal range, epsilon saturates
    add_row(1, CFG_ALPHA, 12'hFFF, 1, 1, 1, 0, 0, 0);
    add_row(1, CFG_DELTA, 12'd100, BYTES_MAX, 1, 1, 0, 0, 0);
    add_row(0, CFG_GAMMA, 0, BYTES_MAX, 1, 1, 0, 0, 0);
    // weight of 127: the older average gets a negative weight
    add_row(1, CFG_DELTA, 12'hFFF, 0, 1, RTT_MAX, 0, 0, 0);
    add_row(1, CFG_ALPHA, 12'd0, 0, 1, RTT_MAX, 0, 0, 0);
    // falling rate pulls the window to the negative rail
    add_row(0, CFG_GAMMA, 0, 0, 1, RTT_MAX, 0, 0, 0);
    add_row(0, CFG_GAMMA, 0, 0, 1, RTT_MAX, 0, 0, 0);
    add_row(0, CFG_GAMMA, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, CFG_GAMMA, 12'h000, 5, 7, 3, 0, 0, 0);
    // write to the undecoded slot changes nothing
    add_row(1, CFG_SPARE, 12'hABC, 1000, 3, 77, 0, 0, 0);
    add_row(1, CFG_ALPHA, 12'd2147, BYTES_MAX, 40'h80_0000_0000, 31'h4000_0000, 0, 0, 0);
    add_row(1, CFG_DELTA, 12'd0, 123456, 654321, 1, 0, 0, 0);
    add_row(1, CFG_GAMMA, 12'd100, 1, ELAPSED_MAX, 1, 0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_en) write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      send_period(directed_rows[i]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // register settings per phase: the rails first, then random, reset values last
      case (ph)
        0: begin
          g = 12'd255;
          a = 12'd2147;
          d = 12'd100;
        end
        1: begin
          g = 12'd0;
          a = 12'd0;
          d = 12'd0;
        end
        2: begin
          g = 12'd1;
          a = 12'hFFF;
          d = 12'hFFF;
        end
        3, 4: begin
          g = CFG_DATA_W'($urandom);
          a = CFG_DATA_W'($urandom);
          d = CFG_DATA_W'($urandom);
        end
        default: begin
          g = GAMMA_RST;
          a = ALPHA_RST;
          d = DELTA_RST;
        end
      endcase
      // no idling at all in the closing phase
      if (ph == PHASES - 1) calm = 1'b1;
      write_reg(CFG_GAMMA, g);
      write_reg(CFG_ALPHA, a);
      write_reg(CFG_DELTA, d);
      if (ph == 3 || ph == 4) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      for (int n = 0; n < PHASE_WORDS; n++) send_period(random_period());
    end

    in_valid  <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall bursts, one long hold so the block backs up
  initial begin : receiver
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && words_sent >= PRESSURE_AT) begin
        out_stall <= 1'b1;
        repeat (PRESSURE_HOLD) @(posedge clk);
        held = 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(2) == 0);
        repeat ($urandom_range(16, 1)) @(posedge clk);
      end
    end
  end

  // compare each accepted result word with the oldest expected window
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", longint'($signed(out_window_size)), 0);
      end else begin
        head_word = expected_words.pop_front();
        if (out_window_size !== head_word.window)
          report_mismatch("window_size", longint'($signed(out_window_size)),
                          longint'($signed(head_word.window)));
        if (out_div_error !== head_word.div_error)
          report_mismatch("div_error", longint'(out_div_error),
                          longint'(head_word.div_error));
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
